// File: hdl/rrp_pkg.sv
// Shared types and constants for the request stream parser.
// Holds the parse-mode enum, the state/event/config structs and the event codes.
// No dependencies.
package rrp_pkg;

    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_INLINE   = 4'd1,
        M_COUNT    = 4'd2,
        M_COUNT_LF = 4'd3,
        M_DOLLAR   = 4'd4,
        M_LEN      = 4'd5,
        M_LEN_LF   = 4'd6,
        M_DATA     = 4'd7,
        M_DATA_CR  = 4'd8,
        M_DATA_LF  = 4'd9,
        M_ERROR    = 4'd10
    } mode_t;

    // event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ARG_BYTE  = 3'd1;
    localparam logic [2:0] EV_ARG_END   = 3'd2;
    localparam logic [2:0] EV_CMD_END   = 3'd3;
    localparam logic [2:0] EV_PROTO_ERR = 3'd4;

    // protocol error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LINE_LONG = 3'd1;
    localparam logic [2:0] ERR_BAD_COUNT = 3'd2;
    localparam logic [2:0] ERR_NO_DOLLAR = 3'd3;
    localparam logic [2:0] ERR_BAD_LEN   = 3'd4;
    localparam logic [2:0] ERR_MISMATCH  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_MAX  = 2'd0;
    localparam logic [1:0] CFG_COUNT_MAX = 2'd1;
    localparam logic [1:0] CFG_LEN_MAX   = 2'd2;

    localparam logic [16:0] LINE_MAX_RST  = 17'h10000;
    localparam logic [20:0] COUNT_MAX_RST = 21'h100000;
    localparam logic [29:0] LEN_MAX_RST   = 30'h20000000;

    localparam logic [29:0] NUM_SAT = 30'h3FFFFFFF;
    localparam logic [20:0] CNT_SAT = 21'h1FFFFF;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [16:0] line_max;
        logic [20:0] count_max;
        logic [29:0] len_max;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [20:0] args_rem;
        logic [29:0] bytes_rem;
        logic [29:0] accum;
        logic        neg;
        logic [16:0] line_len;
        logic [20:0] arg_cnt;
        logic        in_word;
    } pstate_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [19:0] index;
        logic [2:0]  err;
    } event_t;

endpackage

// File: hdl/rrp_core.sv
// Parser state register and the per-byte next-state and event logic.
// Depends on rrp_pkg (mode enum, state/event/config structs, codes).
module rrp_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    data_byte,
    input  logic          new_connection,
    input  rrp_pkg::cfg_t cfg,
    output rrp_pkg::event_t ev
);

    rrp_pkg::pstate_t state_reg;
    rrp_pkg::pstate_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        rrp_pkg::pstate_t cur;
        logic [16:0] lim;
        logic [16:0] seen;
        logic        is_count;
        logic        is_digit;
        logic [3:0]  digit;
        logic [33:0] acc_mul;
        logic [29:0] acc_sat;
        logic        num_ok;
        logic [20:0] cnt_bump;
        logic        eff_word;
        logic [20:0] eff_cnt;
        logic [16:0] eff_len;

        cur = state_reg;
        if (new_connection)
        begin
            cur = '0;
        end
        state_next = cur;
        ev = '0;

        lim = (cfg.line_max == 17'd0) ? 17'd1 : cfg.line_max;
        seen = cur.line_len - 17'd1 - {16'd0, cur.neg};
        is_count = (cur.mode == rrp_pkg::M_COUNT);
        is_digit = (data_byte >= rrp_pkg::CH_ZERO) && (data_byte <= rrp_pkg::CH_NINE);
        digit = data_byte[3:0];
        acc_mul = {1'b0, cur.accum, 3'd0} + {3'd0, cur.accum, 1'b0} + {30'd0, digit};
        acc_sat = (acc_mul >= {4'd0, rrp_pkg::NUM_SAT}) ? rrp_pkg::NUM_SAT : acc_mul[29:0];
        cnt_bump = (cur.arg_cnt < rrp_pkg::CNT_SAT) ? cur.arg_cnt + 21'd1 : cur.arg_cnt;

        // strict decimal: optional leading minus on counts, no leading zeros, no "-0"
        if (data_byte == rrp_pkg::CH_MINUS)
        begin
            num_ok = is_count && (cur.line_len == 17'd1);
        end
        else if (!is_digit)
        begin
            num_ok = 1'b0;
        end
        else if ((seen != 17'd0) && (cur.accum == 30'd0))
        begin
            num_ok = 1'b0;
        end
        else if ((seen == 17'd0) && cur.neg && (data_byte == rrp_pkg::CH_ZERO))
        begin
            num_ok = 1'b0;
        end
        else
        begin
            num_ok = 1'b1;
        end

        // inline line view: an idle parser starts a fresh line
        if (cur.mode == rrp_pkg::M_IDLE)
        begin
            eff_word = 1'b0;
            eff_cnt  = 21'd0;
            eff_len  = 17'd0;
        end
        else
        begin
            eff_word = cur.in_word;
            eff_cnt  = cur.arg_cnt;
            eff_len  = cur.line_len;
        end

        unique case (cur.mode)
            rrp_pkg::M_IDLE,
            rrp_pkg::M_INLINE:
            begin
                state_next.in_word  = eff_word;
                state_next.arg_cnt  = eff_cnt;
                state_next.line_len = eff_len;
                if ((cur.mode == rrp_pkg::M_IDLE) && (data_byte == rrp_pkg::CH_STAR))
                begin
                    state_next.mode     = rrp_pkg::M_COUNT;
                    state_next.line_len = 17'd1;
                    state_next.accum    = 30'd0;
                    state_next.neg      = 1'b0;
                end
                else if (data_byte == rrp_pkg::CH_LF)
                begin
                    ev.kind = (eff_word || (eff_cnt != 21'd0)) ?
                              rrp_pkg::EV_CMD_END : rrp_pkg::EV_NONE;
                    state_next.in_word  = 1'b0;
                    state_next.arg_cnt  = 21'd0;
                    state_next.line_len = 17'd0;
                    state_next.mode     = rrp_pkg::M_IDLE;
                end
                else if (eff_len >= lim)
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_LINE_LONG;
                end
                else
                begin
                    state_next.mode     = rrp_pkg::M_INLINE;
                    state_next.line_len = eff_len + 17'd1;
                    if ((data_byte == rrp_pkg::CH_SPACE) || (data_byte == rrp_pkg::CH_CR))
                    begin
                        if (eff_word)
                        begin
                            ev.kind = rrp_pkg::EV_ARG_END;
                            ev.index = eff_cnt[19:0];
                            state_next.arg_cnt = (eff_cnt < rrp_pkg::CNT_SAT) ?
                                                 eff_cnt + 21'd1 : eff_cnt;
                            state_next.in_word = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next.in_word = 1'b1;
                        ev.kind  = rrp_pkg::EV_ARG_BYTE;
                        ev.data  = data_byte;
                        ev.index = eff_cnt[19:0];
                    end
                end
            end
            rrp_pkg::M_COUNT,
            rrp_pkg::M_LEN:
            begin
                if (data_byte == rrp_pkg::CH_CR)
                begin
                    if (is_count)
                    begin
                        if ((seen == 17'd0) || (cur.accum == rrp_pkg::NUM_SAT) ||
                            (!cur.neg && (cur.accum > {9'd0, cfg.count_max})))
                        begin
                            state_next.mode = rrp_pkg::M_ERROR;
                            ev.kind = rrp_pkg::EV_PROTO_ERR;
                            ev.err  = rrp_pkg::ERR_BAD_COUNT;
                        end
                        else
                        begin
                            state_next.mode = rrp_pkg::M_COUNT_LF;
                        end
                    end
                    else
                    begin
                        if ((seen == 17'd0) || (cur.accum == rrp_pkg::NUM_SAT) ||
                            (cur.accum > cfg.len_max))
                        begin
                            state_next.mode = rrp_pkg::M_ERROR;
                            ev.kind = rrp_pkg::EV_PROTO_ERR;
                            ev.err  = rrp_pkg::ERR_BAD_LEN;
                        end
                        else
                        begin
                            state_next.mode = rrp_pkg::M_LEN_LF;
                        end
                    end
                end
                else if (cur.line_len >= lim)
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_LINE_LONG;
                end
                else if (!num_ok)
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = is_count ? rrp_pkg::ERR_BAD_COUNT : rrp_pkg::ERR_BAD_LEN;
                end
                else
                begin
                    if (data_byte == rrp_pkg::CH_MINUS)
                    begin
                        state_next.neg = 1'b1;
                    end
                    else
                    begin
                        state_next.accum = acc_sat;
                    end
                    state_next.line_len = cur.line_len + 17'd1;
                end
            end
            rrp_pkg::M_COUNT_LF:
            begin
                if (data_byte != rrp_pkg::CH_LF)
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_BAD_COUNT;
                end
                else if (cur.neg || (cur.accum == 30'd0))
                begin
                    state_next = '0;
                end
                else
                begin
                    state_next.args_rem = cur.accum[20:0];
                    state_next.arg_cnt  = 21'd0;
                    state_next.line_len = 17'd0;
                    state_next.mode     = rrp_pkg::M_DOLLAR;
                end
            end
            rrp_pkg::M_DOLLAR:
            begin
                if (data_byte == rrp_pkg::CH_DOLLAR)
                begin
                    state_next.mode     = rrp_pkg::M_LEN;
                    state_next.line_len = 17'd1;
                    state_next.accum    = 30'd0;
                    state_next.neg      = 1'b0;
                end
                else
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_NO_DOLLAR;
                end
            end
            rrp_pkg::M_LEN_LF:
            begin
                if (data_byte != rrp_pkg::CH_LF)
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_BAD_LEN;
                end
                else
                begin
                    state_next.bytes_rem = cur.accum;
                    state_next.line_len  = 17'd0;
                    state_next.mode = (cur.accum != 30'd0) ? rrp_pkg::M_DATA : rrp_pkg::M_DATA_CR;
                end
            end
            rrp_pkg::M_DATA:
            begin
                ev.kind  = rrp_pkg::EV_ARG_BYTE;
                ev.data  = data_byte;
                ev.index = cur.arg_cnt[19:0];
                if (cur.bytes_rem <= 30'd1)
                begin
                    state_next.bytes_rem = 30'd0;
                    state_next.mode = rrp_pkg::M_DATA_CR;
                end
                else
                begin
                    state_next.bytes_rem = cur.bytes_rem - 30'd1;
                end
            end
            rrp_pkg::M_DATA_CR:
            begin
                if (data_byte == rrp_pkg::CH_CR)
                begin
                    ev.kind  = rrp_pkg::EV_ARG_END;
                    ev.index = cur.arg_cnt[19:0];
                    state_next.mode = rrp_pkg::M_DATA_LF;
                end
                else
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_MISMATCH;
                end
            end
            rrp_pkg::M_DATA_LF:
            begin
                if (data_byte != rrp_pkg::CH_LF)
                begin
                    state_next.mode = rrp_pkg::M_ERROR;
                    ev.kind = rrp_pkg::EV_PROTO_ERR;
                    ev.err  = rrp_pkg::ERR_MISMATCH;
                end
                else if (cur.args_rem <= 21'd1)
                begin
                    ev.kind = rrp_pkg::EV_CMD_END;
                    state_next = '0;
                end
                else
                begin
                    state_next.arg_cnt  = cnt_bump;
                    state_next.args_rem = cur.args_rem - 21'd1;
                    state_next.mode     = rrp_pkg::M_DOLLAR;
                end
            end
            default:
            begin
                state_next.mode = rrp_pkg::M_ERROR;
            end
        endcase
    end

    // an error event always parks the parser in the error mode
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (ev.kind == rrp_pkg::EV_PROTO_ERR) |=> state_reg.mode == rrp_pkg::M_ERROR)
        else $error("error event did not enter error mode");

    // a command end always leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (ev.kind == rrp_pkg::EV_CMD_END) |=> state_reg.mode == rrp_pkg::M_IDLE)
        else $error("command end did not return to idle");

    // the error mode is left only through a new connection
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (state_reg.mode == rrp_pkg::M_ERROR) && !new_connection
        |-> ev.kind == rrp_pkg::EV_NONE)
        else $error("event produced while in error mode");

endmodule

// File: hdl/resp_request_parser.sv
// Top level of the request stream parser: channels, config registers, pipeline.
// Depends on rrp_pkg and rrp_core.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one byte of the client
//   request stream per transaction, with new_connection set on the first
//   byte of a fresh connection. The output channel (out_valid/out_ready)
//   returns exactly one event per input byte, in order: none, argument
//   byte, argument end, command end or protocol error with its code.
//   The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
//   writes the line, count and length limits; it is always ready and is
//   meant to be used only while no byte is in flight.
//   An accepted byte enters the input register; from there the parse logic
//   loads its event into the event register, which drives the output.
//   Throughput is one byte per cycle while the receiver keeps taking events,
//   set by the parse step working on the running state.
//   A stalled receiver holds the event register; the input register still
//   takes one more byte, after which in_ready drops until the event leaves.
//   Reset clears the parser to idle with no pending transactions and loads
//   the default limits.
module resp_request_parser (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        new_connection,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  arg_byte,
    output logic [19:0] arg_index,
    output logic [2:0]  error_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [29:0] cfg_data
);

    rrp_pkg::cfg_t   cfg_reg;
    rrp_pkg::event_t ev;
    rrp_pkg::event_t out_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_newc_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       step_en;

    // the event register moves whenever it is empty or being taken
    assign advance   = !out_valid_reg || out_ready;
    assign step_en   = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_max  <= rrp_pkg::LINE_MAX_RST;
            cfg_reg.count_max <= rrp_pkg::COUNT_MAX_RST;
            cfg_reg.len_max   <= rrp_pkg::LEN_MAX_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rrp_pkg::CFG_LINE_MAX:  cfg_reg.line_max  <= cfg_data[16:0];
                rrp_pkg::CFG_COUNT_MAX: cfg_reg.count_max <= cfg_data[20:0];
                rrp_pkg::CFG_LEN_MAX:   cfg_reg.len_max   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // input register: hold while the step is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_newc_reg <= new_connection;
        end
    end

    rrp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .data_byte      (s1_byte_reg),
        .new_connection (s1_newc_reg),
        .cfg            (cfg_reg),
        .ev             (ev)
    );

    // event register: advance when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_reg <= ev;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = out_reg.kind;
    assign arg_byte   = out_reg.data;
    assign arg_index  = out_reg.index;
    assign error_code = out_reg.err;

    // an error code comes with the error event and with nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_res == rrp_pkg::EV_PROTO_ERR) == (error_code != rrp_pkg::ERR_NONE)))
        else $error("error code and event kind disagree");

    // a data byte is shown only with an argument byte event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != rrp_pkg::EV_ARG_BYTE) |-> arg_byte == 8'd0)
        else $error("stray argument byte");

    // a blocked step keeps its byte in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input register lost a pending byte");

endmodule

// File: tb/sv/resp_request_parser_tb.sv
// Self-checking testbench for resp_request_parser, the byte-serial request stream parser.
// Depends on rrp_pkg for the parse modes, event codes, limits and character constants.
// Feeds random RESP traffic and compares every event against an in-bench parser copy.
module resp_request_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Receiver hold-off for the fill-up check, and the watchdog limit on quiet cycles.
    localparam int LONG_HOLD   = 80;
    localparam int STALL_LIMIT = 1000;

    localparam string CR   = "\015";
    localparam string LF   = "\012";
    localparam string CRLF = "\015\012";

    // Scoreboard: a cycle-free copy of the parser that turns each accepted input byte into
    // the event it must cause, plus the queue of events still owed by the block.
    class rrp_event_book;
        logic [16:0] line_limit;
        logic [20:0] count_limit;
        logic [29:0] len_limit;

        rrp_pkg::mode_t mode;
        logic [20:0] args_left;
        logic [29:0] bytes_left;
        logic [29:0] num;
        logic        num_neg;
        logic [16:0] line_len;
        logic [20:0] arg_cnt;
        logic        word_open;

        rrp_pkg::event_t step_ev;
        rrp_pkg::event_t owed_events[$];
        int          misses;

        function new();
            line_limit  = rrp_pkg::LINE_MAX_RST;
            count_limit = rrp_pkg::COUNT_MAX_RST;
            len_limit   = rrp_pkg::LEN_MAX_RST;
            misses      = 0;
            clear_parse();
        endfunction

        function void set_limit(logic [1:0] idx, logic [29:0] val);
            case (idx)
                rrp_pkg::CFG_LINE_MAX:  line_limit  = val[16:0];
                rrp_pkg::CFG_COUNT_MAX: count_limit = val[20:0];
                rrp_pkg::CFG_LEN_MAX:   len_limit   = val;
                default: ;
            endcase
        endfunction

        function void clear_parse();
            mode       = rrp_pkg::M_IDLE;
            args_left  = '0;
            bytes_left = '0;
            num        = '0;
            num_neg    = 1'b0;
            line_len   = '0;
            arg_cnt    = '0;
            word_open  = 1'b0;
        endfunction

        function void flag_error(logic [2:0] code);
            mode         = rrp_pkg::M_ERROR;
            step_ev.kind = rrp_pkg::EV_PROTO_ERR;
            step_ev.err  = code;
        endfunction

        // A zero line limit behaves like a limit of one.
        function bit line_full();
            int lim;
            lim = (line_limit == 0) ? 1 : int'(line_limit);
            return int'(line_len) >= lim;
        endfunction

        function int digits_seen();
            return int'(line_len) - 1 - int'(num_neg);
        endfunction

        function void count_arg();
            if (arg_cnt < rrp_pkg::CNT_SAT)
                arg_cnt = arg_cnt + 21'd1;
        endfunction

        function void open_number();
            line_len = 17'd1;
            num      = '0;
            num_neg  = 1'b0;
        endfunction

        // Strict decimal: one leading minus where allowed, no leading zeros, no "-0";
        // the magnitude saturates and a saturated value is rejected at CR.
        function bit take_digit(logic [7:0] c, bit allow_neg);
            longint v;
            if (c == rrp_pkg::CH_MINUS)
            begin
                if (!allow_neg || line_len != 17'd1)
                    return 1'b0;
                num_neg = 1'b1;
                return 1'b1;
            end
            if (c < rrp_pkg::CH_ZERO || c > rrp_pkg::CH_NINE)
                return 1'b0;
            if (digits_seen() > 0 && num == 0)
                return 1'b0;
            if (digits_seen() == 0 && num_neg && c == rrp_pkg::CH_ZERO)
                return 1'b0;
            v = longint'(num) * 10 + longint'(c - rrp_pkg::CH_ZERO);
            num = (v >= longint'(rrp_pkg::NUM_SAT)) ? rrp_pkg::NUM_SAT : v[29:0];
            return 1'b1;
        endfunction

        function void inline_step(logic [7:0] c);
            mode = rrp_pkg::M_INLINE;
            if (c == rrp_pkg::CH_LF)
            begin
                step_ev.kind = (word_open || arg_cnt > 0) ?
                               rrp_pkg::EV_CMD_END : rrp_pkg::EV_NONE;
                word_open = 1'b0;
                arg_cnt   = '0;
                line_len  = '0;
                mode      = rrp_pkg::M_IDLE;
                return;
            end
            if (line_full())
            begin
                flag_error(rrp_pkg::ERR_LINE_LONG);
                return;
            end
            line_len = line_len + 17'd1;
            if (c == rrp_pkg::CH_SPACE || c == rrp_pkg::CH_CR)
            begin
                if (word_open)
                begin
                    step_ev.kind  = rrp_pkg::EV_ARG_END;
                    step_ev.index = arg_cnt[19:0];
                    count_arg();
                    word_open = 1'b0;
                end
                return;
            end
            word_open     = 1'b1;
            step_ev.kind  = rrp_pkg::EV_ARG_BYTE;
            step_ev.data  = c;
            step_ev.index = arg_cnt[19:0];
        endfunction

        // Advance the parser copy by one accepted byte and queue the event it owes.
        function void take_byte(logic [7:0] c, logic nc);
            bit is_count;
            step_ev = '0;
            if (nc)
                clear_parse();
            case (mode)
                rrp_pkg::M_IDLE:
                begin
                    arg_cnt   = '0;
                    word_open = 1'b0;
                    line_len  = '0;
                    if (c == rrp_pkg::CH_STAR)
                    begin
                        mode = rrp_pkg::M_COUNT;
                        open_number();
                    end
                    else
                        inline_step(c);
                end
                rrp_pkg::M_INLINE: inline_step(c);
                rrp_pkg::M_COUNT, rrp_pkg::M_LEN:
                begin
                    is_count = (mode == rrp_pkg::M_COUNT);
                    if (c == rrp_pkg::CH_CR)
                    begin
                        if (is_count)
                        begin
                            if (digits_seen() == 0 || num == rrp_pkg::NUM_SAT ||
                                (!num_neg && num > count_limit))
                                flag_error(rrp_pkg::ERR_BAD_COUNT);
                            else
                                mode = rrp_pkg::M_COUNT_LF;
                        end
                        else
                        begin
                            if (digits_seen() == 0 || num == rrp_pkg::NUM_SAT ||
                                num > len_limit)
                                flag_error(rrp_pkg::ERR_BAD_LEN);
                            else
                                mode = rrp_pkg::M_LEN_LF;
                        end
                    end
                    else if (line_full())
                        flag_error(rrp_pkg::ERR_LINE_LONG);
                    else if (!take_digit(c, is_count))
                        flag_error(is_count ? rrp_pkg::ERR_BAD_COUNT : rrp_pkg::ERR_BAD_LEN);
                    else
                        line_len = line_len + 17'd1;
                end
                rrp_pkg::M_COUNT_LF:
                begin
                    if (c != rrp_pkg::CH_LF)
                        flag_error(rrp_pkg::ERR_BAD_COUNT);
                    else if (num_neg || num == 0)
                        clear_parse();
                    else
                    begin
                        args_left = num[20:0];
                        arg_cnt   = '0;
                        line_len  = '0;
                        mode      = rrp_pkg::M_DOLLAR;
                    end
                end
                rrp_pkg::M_DOLLAR:
                begin
                    if (c == rrp_pkg::CH_DOLLAR)
                    begin
                        mode = rrp_pkg::M_LEN;
                        open_number();
                    end
                    else
                        flag_error(rrp_pkg::ERR_NO_DOLLAR);
                end
                rrp_pkg::M_LEN_LF:
                begin
                    if (c != rrp_pkg::CH_LF)
                        flag_error(rrp_pkg::ERR_BAD_LEN);
                    else
                    begin
                        bytes_left = num;
                        line_len   = '0;
                        mode       = (num != 0) ? rrp_pkg::M_DATA : rrp_pkg::M_DATA_CR;
                    end
                end
                rrp_pkg::M_DATA:
                begin
                    step_ev.kind  = rrp_pkg::EV_ARG_BYTE;
                    step_ev.data  = c;
                    step_ev.index = arg_cnt[19:0];
                    if (bytes_left > 0)
                        bytes_left = bytes_left - 30'd1;
                    if (bytes_left == 0)
                        mode = rrp_pkg::M_DATA_CR;
                end
                rrp_pkg::M_DATA_CR:
                begin
                    if (c == rrp_pkg::CH_CR)
                    begin
                        step_ev.kind  = rrp_pkg::EV_ARG_END;
                        step_ev.index = arg_cnt[19:0];
                        mode          = rrp_pkg::M_DATA_LF;
                    end
                    else
                        flag_error(rrp_pkg::ERR_MISMATCH);
                end
                rrp_pkg::M_DATA_LF:
                begin
                    if (c != rrp_pkg::CH_LF)
                        flag_error(rrp_pkg::ERR_MISMATCH);
                    else
                    begin
                        count_arg();
                        if (args_left > 0)
                            args_left = args_left - 21'd1;
                        if (args_left == 0)
                        begin
                            step_ev.kind = rrp_pkg::EV_CMD_END;
                            clear_parse();
                        end
                        else
                            mode = rrp_pkg::M_DOLLAR;
                    end
                end
                default: mode = rrp_pkg::M_ERROR;
            endcase
            owed_events.push_back(step_ev);
        endfunction

        function int owed_count();
            return owed_events.size();
        endfunction

        function void match_event(logic [2:0] kind, logic [7:0] data, logic [19:0] index,
                                  logic [2:0] err);
            rrp_pkg::event_t want;
            if (owed_events.size() == 0)
            begin
                misses++;
                $display("%0t: unexpected event, kind %0d byte %0h index %0d code %0d",
                         $time, kind, data, index, err);
                return;
            end
            want = owed_events.pop_front();
            if (kind !== want.kind)
            begin
                misses++;
                $display("%0t: event_res expected %0d, got %0d", $time, want.kind, kind);
            end
            if (data !== want.data)
            begin
                misses++;
                $display("%0t: arg_byte expected %0h, got %0h", $time, want.data, data);
            end
            if (index !== want.index)
            begin
                misses++;
                $display("%0t: arg_index expected %0d, got %0d", $time, want.index, index);
            end
            if (err !== want.err)
            begin
                misses++;
                $display("%0t: error_code expected %0d, got %0d", $time, want.err, err);
            end
        endfunction
    endclass

    typedef struct packed {
        logic       nc;
        logic [7:0] b;
    } wire_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        new_connection = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_res;
    logic [7:0]  arg_byte;
    logic [19:0] arg_index;
    logic [2:0]  error_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [29:0] cfg_data = '0;

    rrp_event_book book = new();
    wire_byte_t    outgoing[$];
    bit            fresh_conn = 1'b0;
    bit            hold_rx = 1'b0;
    bit            calm = 1'b0;
    int            quiet_cycles = 0;

    resp_request_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .new_connection (new_connection),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .arg_byte       (arg_byte),
        .arg_index      (arg_index),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Stream builders: append bytes to the outgoing queue. The first byte after
    // fresh_conn is set carries new_connection.
    // ---------------------------------------------------------------------------------
    function automatic void put(logic [7:0] b);
        wire_byte_t w;
        w.nc = fresh_conn;
        w.b  = b;
        outgoing.push_back(w);
        fresh_conn = 1'b0;
    endfunction

    function automatic void put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    // A '*' or '$' header line carrying a decimal number.
    function automatic void put_number_line(logic [7:0] lead, longint n);
        put(lead);
        put_text($sformatf("%0d", n));
        put_text(CRLF);
    endfunction

    function automatic void put_multibulk(int nargs, int maxlen);
        int a;
        int len;
        put_number_line(rrp_pkg::CH_STAR, nargs);
        for (a = 0; a < nargs; a++)
        begin
            len = $urandom_range(0, maxlen);
            put_number_line(rrp_pkg::CH_DOLLAR, len);
            repeat (len) put(8'($urandom_range(0, 255)));
            put_text(CRLF);
        end
    endfunction

    // Inline line: words of any byte but space, CR, LF or '*', split by spaces or CR.
    function automatic void put_inline();
        int w;
        int words;
        logic [7:0] ch;
        words = $urandom_range(0, 4);
        for (w = 0; w < words; w++)
        begin
            repeat ($urandom_range(w == 0 ? 0 : 1, 2))
                put($urandom_range(0, 3) == 0 ? rrp_pkg::CH_CR : rrp_pkg::CH_SPACE);
            repeat ($urandom_range(1, 6))
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == rrp_pkg::CH_SPACE || ch == rrp_pkg::CH_CR ||
                       ch == rrp_pkg::CH_LF || ch == rrp_pkg::CH_STAR);
                put(ch);
            end
        end
        if ($urandom_range(0, 2) == 0)
            put(rrp_pkg::CH_SPACE);
        if ($urandom_range(0, 1) == 0)
            put(rrp_pkg::CH_CR);
        put(rrp_pkg::CH_LF);
    endfunction

    // Malformed or boundary requests; always followed by a fresh connection.
    function automatic void put_odd();
        int first;
        int n;
        fresh_conn = 1'b1;
        first = outgoing.size();
        case ($urandom_range(0, 25))
            0:  put_text({"*01", CRLF});                       // leading zero in count
            1:  put_text({"*-0", CRLF});                       // negative zero
            2:  put_text({"*+1", CRLF});                       // plus sign
            3:  put_text({"*-", CRLF});                        // sign without digits
            4:  put_text({"*", CRLF});                         // empty count
            5:  put_text({"*99999999999", CRLF, "$1", CRLF});  // saturated count
            6:  put_text({"*1 ", CRLF});                       // trailing space
            7:  put_text({"*1", CR, "x"});                     // CR not followed by LF
            8:  put_text({"*1", CRLF, "x1", CRLF});            // argument without dollar
            9:  put_text({"*1", CRLF, "$-1", CRLF});           // negative length
            10: put_text({"*1", CRLF, "$01", CRLF});           // leading zero in length
            11: put_text({"*1", CRLF, "$", CRLF});             // empty length
            12: put_text({"*1", CRLF, "$2", CRLF, "abc", CRLF}); // too many data bytes
            13: put_text({"*1", CRLF, "$2", CRLF, "ab", CR, "x"}); // CR then junk
            14: put_text({"*1", CRLF, "$1", CRLF, "a", LF});   // LF where CR belongs
            15: put_text({"*1", CRLF, "$999999999999", CRLF}); // saturated length
            16: put_text({"*1", CRLF, "$3x"});                 // junk in length
            17: put_text({"*-7", CRLF});                       // negative count, no command
            18: put_text({"*--1", CRLF});                      // second minus
            19: put_text({"*2", CRLF, "$0", CRLF, CRLF, "$1", CRLF, "z", CRLF});
            20:
            begin
                // count exactly at the limit, then one argument
                put_number_line(rrp_pkg::CH_STAR, longint'(book.count_limit));
                put_text({"$1", CRLF, "q", CRLF});
            end
            21: put_number_line(rrp_pkg::CH_STAR, longint'(book.count_limit) + 1);
            22:
            begin
                // length exactly at the limit, then a few data bytes
                put_text({"*1", CRLF});
                put_number_line(rrp_pkg::CH_DOLLAR, longint'(book.len_limit));
                repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
            end
            23:
            begin
                put_text({"*1", CRLF});
                put_number_line(rrp_pkg::CH_DOLLAR, longint'(book.len_limit) + 1);
            end
            24:
            begin
                // request cut short by a new connection
                put_multibulk(2, 3);
                repeat ($urandom_range(1, 5)) void'(outgoing.pop_back());
            end
            default:
            begin
                // overlong header or inline line when the limit is small
                n = (int'(book.line_limit) < 20) ? int'(book.line_limit) + 1 : 20;
                if ($urandom_range(0, 1) == 0)
                begin
                    put(rrp_pkg::CH_STAR);
                    repeat (n) put("1");
                    put_text(CRLF);
                end
                else
                begin
                    repeat (n) put("a");
                    put(rrp_pkg::CH_LF);
                end
            end
        endcase
        if (outgoing.size() > first)
            outgoing[first].nc = 1'b1;
        fresh_conn = 1'b1;
    endfunction

    // Mostly well-formed requests with random content; the rest broken or noise.
    function automatic void put_request(int maxargs, int maxlen);
        int pick;
        int first;
        if ($urandom_range(0, 3) == 0)
            fresh_conn = 1'b1;
        pick = $urandom_range(0, 19);
        if (pick < 11)
            put_multibulk($urandom_range(1, maxargs), maxlen);
        else if (pick < 15)
            put_inline();
        else if (pick < 18)
            put_odd();
        else if (pick == 18)
        begin
            repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
            fresh_conn = 1'b1;
        end
        else
        begin
            // flip one byte of a good request
            first = outgoing.size();
            put_multibulk($urandom_range(1, maxargs), maxlen);
            outgoing[$urandom_range(first, outgoing.size() - 1)].b = 8'($urandom_range(0, 255));
            fresh_conn = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------------------------
    // Drivers. Inputs change by nonblocking assignment at the rising edge; handshakes
    // are read right after the edge, so they reflect values from before it.
    // ---------------------------------------------------------------------------------

    // Offer one byte; optionally drop valid for a burst first.
    task automatic offer(input logic [7:0] b, input logic nc);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        new_connection <= nc;
        do
            @(posedge clk);
        while (!in_ready);
        book.take_byte(b, nc);
    endtask

    // Send everything queued; valid stays high after the last transaction.
    task automatic send_all();
        wire_byte_t w;
        while (outgoing.size() > 0)
        begin
            w = outgoing.pop_front();
            offer(w.b, w.nc);
        end
    endtask

    task automatic run_traffic(int target, int maxargs, int maxlen);
        while (outgoing.size() < target)
            put_request(maxargs, maxlen);
        send_all();
    endtask

    // Drop valid and hold until every owed event has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (book.owed_count() != 0);
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [29:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_limit(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all limits while idle; the extra cycles cover the two-stage pipeline.
    task automatic set_limits(input logic [29:0] line_max, input logic [29:0] count_max,
                              input logic [29:0] len_max);
        drain();
        repeat (4) @(posedge clk);
        write_limit(rrp_pkg::CFG_LINE_MAX, line_max);
        write_limit(rrp_pkg::CFG_COUNT_MAX, count_max);
        write_limit(rrp_pkg::CFG_LEN_MAX, len_max);
    endtask

    // Receiver: random stall bursts, one long hold on request, none once calm.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rx = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Check every event transaction against the oldest owed event.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            book.match_event(event_res, arg_byte, arg_index, error_code);
    end

    // Watchdog: end the run if no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[resp_request_parser] ERROR");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: null and zero counts, one command with extreme data bytes,
        // an inline word, then a bad count character.
        fresh_conn = 1'b1;
        put_text({"*-1", CRLF});
        put_text({"*0", CRLF});
        put_text({"*1", CRLF, "$2", CRLF});
        put(8'h00);
        put(8'hFF);
        put_text(CRLF);
        put_text({" x", LF});
        put_text("*x");
        fresh_conn = 1'b1;
        send_all();

        // Sender pause until every owed event is back, then random traffic at reset limits.
        drain();
        run_traffic(110, 3, 6);

        // Long receiver hold while bytes keep coming, so the input side backs up.
        hold_rx = 1'b1;
        run_traffic(40, 3, 6);

        // Small limits.
        set_limits(30'($urandom_range(4, 12)), 30'($urandom_range(2, 3)),
                   30'($urandom_range(3, 6)));
        run_traffic(100, 3, 6);

        // Lowest limits, line limit zero behaving as one.
        set_limits(30'd0, 30'd1, 30'd1);
        run_traffic(40, 2, 2);
        set_limits(30'd1, 30'd1, 30'd1);
        run_traffic(20, 2, 2);

        // Reset default limits again, then a final stretch with no idling on either side.
        set_limits(30'(rrp_pkg::LINE_MAX_RST), 30'(rrp_pkg::COUNT_MAX_RST),
                   30'(rrp_pkg::LEN_MAX_RST));
        run_traffic(80, 3, 8);
        calm = 1'b1;
        run_traffic(50, 3, 8);

        drain();
        repeat (8) @(posedge clk);
        if (book.misses == 0 && book.owed_count() == 0)
            $display("[resp_request_parser] OK");
        else
            $display("[resp_request_parser] ERROR");
        $finish;
    end
endmodule

// File: resp_request_parser.f
hdl/rrp_pkg.sv
hdl/rrp_core.sv
hdl/resp_request_parser.sv
tb/sv/resp_request_parser_tb.sv
